[src/chirp_tone_decay_gen_assert.svh]
// Assertion macros for the chirp tone generator.
// Included by the top level; needs nothing else.
`ifndef CHIRP_TONE_DECAY_GEN_ASSERT_SVH
`define CHIRP_TONE_DECAY_GEN_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define CTDG_ASSERT_ALWAYS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define CTDG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ctdg_pkg.sv]
// Shared types and constants of the chirp tone generator.
// Used by ctdg_sine_rom and chirp_tone_decay_gen; depends on nothing.
package ctdg_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_COUNT     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_INCREMENT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INCREMENT_STEP  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_FACTOR    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE       = 3'd4;

  // Widths fixed by the register map
  localparam int FRAME_CFG_BITS = 20;
  localparam int DECAY_BITS     = 16;
  localparam int AMP_BITS       = 15;
  localparam int ENV_BITS       = 17;
  localparam int WORD_BITS      = 15;
  localparam int SAMPLE_BITS    = 16;

  // Shared multiplier operand and product widths
  localparam int MUL_A_BITS = 32;
  localparam int MUL_B_BITS = 17;
  localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;
  localparam int PROD_BITS  = 47;

  localparam logic [ENV_BITS-1:0]   ENV_UNITY  = 17'd65536;
  localparam logic [DECAY_BITS-1:0] DECAY_INIT = 16'hFFFF;
  localparam logic [PROD_BITS-1:0]  ROUND_HALF = 47'd1 << 30;
  localparam logic [WORD_BITS-1:0]  SAMPLE_MAX = 15'h7FFF;

  // Fixed-point constants for the sine table
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ROM  = 5'b00010,
    S_MUL1 = 5'b00100,
    S_MUL2 = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  // One quarter-wave entry: 32767*sin(pi/2*(k+0.5)/2^log2), Q30 Taylor series
  function automatic logic [WORD_BITS-1:0] rom_value(input int unsigned k,
                                                     input int unsigned log2);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] y;
    logic [63:0] s;
    logic [63:0] v;
    x  = (PI_HALF_Q30 * (64'(k) * 64'd2 + 64'd1)) >> (log2 + 1);
    x2 = (x * x) >> 30;
    y  = Q30_ONE;
    y  = Q30_ONE - ((x2 * y) >> 30) / 64'd110;
    y  = Q30_ONE - ((x2 * y) >> 30) / 64'd72;
    y  = Q30_ONE - ((x2 * y) >> 30) / 64'd42;
    y  = Q30_ONE - ((x2 * y) >> 30) / 64'd20;
    y  = Q30_ONE - ((x2 * y) >> 30) / 64'd6;
    s  = (x * y) >> 30;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[WORD_BITS-1:0];
  endfunction

endpackage

[src/ctdg_sine_rom.sv]
// Quarter-wave sine ROM with registered read data.
// Entries are built at elaboration from ctdg_pkg::rom_value.
module ctdg_sine_rom #(
  parameter int ADDR_BITS = 10
) (
  input  logic                            clk,
  input  logic [ADDR_BITS-1:0]            addr,
  output logic [ctdg_pkg::WORD_BITS-1:0]  data
);

  localparam int Entries = 1 << ADDR_BITS;

  logic [ctdg_pkg::WORD_BITS-1:0] rom_words [Entries];

  // Constant contents, one word per entry
  for (genvar k = 0; k < Entries; k++) begin : g_word
    localparam logic [ctdg_pkg::WORD_BITS-1:0] Word =
      ctdg_pkg::rom_value(k, ADDR_BITS);
    assign rom_words[k] = Word;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    data <= rom_words[addr];
  end

endmodule

[src/chirp_tone_decay_gen.sv]
// Linear chirp sine generator with exponential decay; uses ctdg_pkg and ctdg_sine_rom.
// A tick accepted in idle passes the ROM, MUL1, MUL2 and EMIT states; EMIT registers
// the item once the output is free. Ticks are taken only in idle, as the shared 32x17
// multiplier (envelope decay, sine times envelope, times amplitude) behind the ROM
// read serves one sample at a time. A tick with no sample stays idle. Synchronous reset
// loads the register defaults and clears the tone; the constant ROM needs no clearing.
`include "chirp_tone_decay_gen_assert.svh"

module chirp_tone_decay_gen #(
  parameter int PHASE_BITS         = 32,
  parameter int SINE_TABLE_ENTRIES = 1024,
  parameter int FRAME_BITS         = 20
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ctdg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [31:0]                            cfg_data,
  // sample ticks
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   restart,
  // tone samples
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ctdg_pkg::SAMPLE_BITS-1:0] sample_value,
  output logic                                   last_sample
);

  // largest power of two not above the table size
  localparam int RomLog2 = $clog2(SINE_TABLE_ENTRIES + 1) - 1;
  localparam int FcBits  = (FRAME_BITS < ctdg_pkg::FRAME_CFG_BITS) ? FRAME_BITS
                                                                    : ctdg_pkg::FRAME_CFG_BITS;

  // configuration registers
  logic [FRAME_BITS-1:0]           frame_count;
  logic [PHASE_BITS-1:0]           start_increment;
  logic [PHASE_BITS-1:0]           increment_step;
  logic [ctdg_pkg::DECAY_BITS-1:0] decay_factor;
  logic [ctdg_pkg::AMP_BITS-1:0]   amplitude;

  // tone state
  ctdg_pkg::state_t                state;
  logic [PHASE_BITS-1:0]           phase_accumulator;
  logic [PHASE_BITS-1:0]           phase_increment;
  logic [ctdg_pkg::ENV_BITS-1:0]   envelope_level;
  logic [ctdg_pkg::ENV_BITS-1:0]   env_decayed;
  logic [FRAME_BITS-1:0]           frames_done;
  logic                            tone_active;
  logic [ctdg_pkg::PROD_BITS-1:0]  prod;

  // combinational
  logic                            in_fire;
  logic                            act_eff;
  logic [FRAME_BITS-1:0]           frames_eff;
  logic [PHASE_BITS-1:0]           phase_eff;
  logic [PHASE_BITS-1:0]           inc_eff;
  logic                            tick_runs;
  logic [1:0]                      quadrant;
  logic [RomLog2-1:0]              rom_raw;
  logic [RomLog2-1:0]              rom_addr;
  logic [ctdg_pkg::WORD_BITS-1:0]  rom_word;
  logic [ctdg_pkg::MUL_A_BITS-1:0] mul_a;
  logic [ctdg_pkg::MUL_B_BITS-1:0] mul_b;
  logic [ctdg_pkg::MUL_P_BITS-1:0] mul_p;
  logic [ctdg_pkg::PROD_BITS-1:0]  prod_rnd;
  logic [ctdg_pkg::SAMPLE_BITS-1:0] mag_q;
  logic [ctdg_pkg::WORD_BITS-1:0]  mag_sat;
  logic signed [ctdg_pkg::SAMPLE_BITS-1:0] mag_ext;
  logic signed [ctdg_pkg::SAMPLE_BITS-1:0] sample_next;
  logic                            last_now;
  logic                            out_free;
  logic                            in_mul1;
  logic                            in_mul2;
  logic                            in_emit;
  logic                            frames_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ctdg_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // state as seen by this tick once a restart is applied
  assign act_eff    = restart || tone_active;
  assign frames_eff = restart ? '0 : frames_done;
  assign phase_eff  = restart ? '0 : phase_accumulator;
  assign inc_eff    = restart ? start_increment : phase_increment;
  assign tick_runs  = act_eff && (frames_eff < frame_count);

  // quadrant decode, odd quadrants run the table backwards
  assign quadrant = phase_accumulator[PHASE_BITS-1 -: 2];
  assign rom_raw  = phase_accumulator[PHASE_BITS-3 -: RomLog2];
  assign rom_addr = quadrant[0] ? ~rom_raw : rom_raw;

  ctdg_sine_rom #(
    .ADDR_BITS (RomLog2)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_word)
  );

  // shared multiplier operand select
  always_comb begin
    case (state)
      ctdg_pkg::S_ROM: begin
        mul_a = ctdg_pkg::MUL_A_BITS'(envelope_level);
        mul_b = ctdg_pkg::MUL_B_BITS'(decay_factor);
      end
      ctdg_pkg::S_MUL1: begin
        mul_a = ctdg_pkg::MUL_A_BITS'(rom_word);
        mul_b = envelope_level;
      end
      ctdg_pkg::S_MUL2: begin
        mul_a = prod[ctdg_pkg::MUL_A_BITS-1:0];
        mul_b = ctdg_pkg::MUL_B_BITS'(amplitude);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = ctdg_pkg::MUL_P_BITS'(mul_a) * ctdg_pkg::MUL_P_BITS'(mul_b);

  // round half up by 2^31, saturate, apply the sine's sign
  assign prod_rnd = prod + ctdg_pkg::ROUND_HALF;
  assign mag_q    = prod_rnd[ctdg_pkg::PROD_BITS-1 -: ctdg_pkg::SAMPLE_BITS];
  assign mag_sat  = (mag_q > ctdg_pkg::SAMPLE_BITS'(ctdg_pkg::SAMPLE_MAX))
                    ? ctdg_pkg::SAMPLE_MAX : mag_q[ctdg_pkg::WORD_BITS-1:0];
  assign mag_ext     = {1'b0, mag_sat};
  assign sample_next = quadrant[1] ? -mag_ext : mag_ext;
  assign last_now    = (frames_done >= frame_count);

  // sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ctdg_pkg::S_IDLE;
      frame_count       <= '0;
      start_increment   <= '0;
      increment_step    <= '0;
      decay_factor      <= ctdg_pkg::DECAY_INIT;
      amplitude         <= '0;
      phase_accumulator <= '0;
      phase_increment   <= '0;
      envelope_level    <= ctdg_pkg::ENV_UNITY;
      frames_done       <= '0;
      tone_active       <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ctdg_pkg::REG_FRAME_COUNT:     frame_count <= FRAME_BITS'(cfg_data[FcBits-1:0]);
          ctdg_pkg::REG_START_INCREMENT: start_increment <= cfg_data[PHASE_BITS-1:0];
          ctdg_pkg::REG_INCREMENT_STEP:  increment_step <= cfg_data[PHASE_BITS-1:0];
          ctdg_pkg::REG_DECAY_FACTOR:
            decay_factor <= cfg_data[ctdg_pkg::DECAY_BITS-1:0];
          ctdg_pkg::REG_AMPLITUDE:       amplitude <= cfg_data[ctdg_pkg::AMP_BITS-1:0];
          default: ;
        endcase
      end

      // the emit step reloads the output itself
      if (out_valid && out_ready && !in_emit) begin
        out_valid <= 1'b0;
      end

      case (state)
        ctdg_pkg::S_IDLE: begin
          if (in_fire) begin
            if (restart) begin
              frames_done     <= '0;
              phase_increment <= start_increment;
              envelope_level  <= ctdg_pkg::ENV_UNITY;
            end
            if (tick_runs) begin
              phase_accumulator <= phase_eff + inc_eff;
              tone_active       <= 1'b1;
              state             <= ctdg_pkg::S_ROM;
            end else begin
              phase_accumulator <= phase_eff;
              tone_active       <= 1'b0;
            end
          end
        end
        ctdg_pkg::S_ROM: begin
          // envelope times decay, Q1.16 kept
          env_decayed <= mul_p[ctdg_pkg::ENV_BITS+15:16];
          state       <= ctdg_pkg::S_MUL1;
        end
        ctdg_pkg::S_MUL1: begin
          prod  <= mul_p[ctdg_pkg::PROD_BITS-1:0];
          state <= ctdg_pkg::S_MUL2;
        end
        ctdg_pkg::S_MUL2: begin
          prod            <= mul_p[ctdg_pkg::PROD_BITS-1:0];
          envelope_level  <= env_decayed;
          phase_increment <= phase_increment + increment_step;
          frames_done     <= frames_done + FRAME_BITS'(1);
          state           <= ctdg_pkg::S_EMIT;
        end
        ctdg_pkg::S_EMIT: begin
          // wait here while the previous item is still held
          if (out_free) begin
            sample_value <= sample_next;
            last_sample  <= last_now;
            out_valid    <= 1'b1;
            if (last_now) begin
              tone_active <= 1'b0;
            end
            state <= ctdg_pkg::S_IDLE;
          end
        end
        default: state <= ctdg_pkg::S_IDLE;
      endcase
    end
  end

  // terms for the checks below
  assign in_mul1   = (state == ctdg_pkg::S_MUL1);
  assign in_mul2   = (state == ctdg_pkg::S_MUL2);
  assign in_emit   = (state == ctdg_pkg::S_EMIT);
  assign frames_ok = (frames_done != '0) && (frames_done <= frame_count);

  // checks on the sequencer
  `CTDG_ASSERT_NEXT(a_frames_in_range, clk, rst, in_mul2, frames_ok, "frame count out of range")
  `CTDG_ASSERT_ALWAYS(a_item_from_emit, clk, rst, $rose(out_valid), $past(in_emit), "stray item")
  `CTDG_ASSERT_ALWAYS(a_busy_tone_live, clk, rst, in_mul1, tone_active, "sample with no tone")

endmodule
